>>> rtl/vrhp_pkg.sv
// Package for the video RAM host port: item layouts, register and flag
// codes, the address step function and the video memory request types.
// No dependencies; vrhp_vram, video_ram_host_port and the testbench use it.
package vrhp_pkg;

	// Host access kinds carried in the func field
	localparam logic [1:0] FUNC_READ  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_LINE  = 2'd2;

	// Host port addresses
	localparam logic [1:0] PORT_SEL    = 2'd0;
	localparam logic [1:0] PORT_UNUSED = 2'd1;
	localparam logic [1:0] PORT_DLO    = 2'd2;
	localparam logic [1:0] PORT_DHI    = 2'd3;

	// Register file
	localparam int unsigned SEL_W    = 5;
	localparam int unsigned NUM_REGS = 32;
	localparam int unsigned ADDR_W   = 15;

	localparam logic [SEL_W-1:0] REG_MAWR = 5'd0;  // write address
	localparam logic [SEL_W-1:0] REG_MARR = 5'd1;  // read address
	localparam logic [SEL_W-1:0] REG_VWR  = 5'd2;  // data word
	localparam logic [SEL_W-1:0] REG_CR   = 5'd5;  // control
	localparam logic [SEL_W-1:0] REG_RCR  = 5'd6;  // raster compare

	// Control register fields
	localparam int unsigned CR_RR_EN  = 2;
	localparam int unsigned CR_VD_EN  = 3;
	localparam int unsigned CR_INC_LO = 11;

	// Status flag bits
	localparam int unsigned FLAG_RR = 2;
	localparam int unsigned FLAG_VD = 5;

	// Raster compare counts lines from this offset
	localparam logic [15:0] LINE_OFFSET = 16'h0040;

	typedef struct packed {
		logic [1:0] func;
		logic [1:0] port;
		logic [7:0] wdata;
		logic [8:0] line;
	} cmd_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic       irq;
	} res_t;

	typedef struct packed {
		logic              wr;
		logic              rd;
		logic [ADDR_W-1:0] addr;
		logic [15:0]       data;
	} vram_req_t;

	typedef struct packed {
		logic        busy;   // a read is still on its way
		logic        valid;  // read word present this cycle
		logic [15:0] data;
	} vram_rsp_t;

	// Step an address by 1, 32, 64 or 128 words, wrapping at 15 bits
	function automatic logic [ADDR_W-1:0] addr_step(input logic [15:0] addr,
			input logic [1:0] code);
		logic [ADDR_W-1:0] inc;
		case (code)
			2'd0:    inc = 15'd1;
			2'd1:    inc = 15'd32;
			2'd2:    inc = 15'd64;
			default: inc = 15'd128;
		endcase
		return addr[ADDR_W-1:0] + inc;
	endfunction

endpackage

>>> rtl/vrhp_stream_if.sv
// Valid/ready channel used for the command and result streams.
// The payload type is set per instance; no other dependencies.
interface vrhp_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> rtl/vrhp_vram.sv
// Video memory with its address reduction pipeline: the 15-bit address is
// folded modulo the memory size in two stages, then the array is accessed.
// Depends on vrhp_pkg.
module vrhp_vram #(
	parameter int unsigned VRAM_WORDS = 32768
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vrhp_pkg::vram_req_t req,
	output vrhp_pkg::vram_rsp_t rsp
);

	localparam int unsigned AW    = $clog2(VRAM_WORDS);
	localparam int unsigned SH    = 30;
	localparam int unsigned PW    = vrhp_pkg::ADDR_W + 21;
	localparam logic [20:0] RECIP = 21'((2 ** SH) / VRAM_WORDS);
	localparam logic [21:0] DIV   = 22'(VRAM_WORDS);

	logic                        wr_s1, rd_s1, wr_s2, rd_s2, wr_s3, rd_s3;
	logic [vrhp_pkg::ADDR_W-1:0] addr_s1, addr_s2;
	logic [15:0]                 data_s1, data_s2, data_s3;
	logic [5:0]                  q_s2;
	logic [AW-1:0]               idx_s3;
	logic [PW-1:0]               prod;
	logic [21:0]                 rem_raw, rem;
	logic [15:0]                 rdata_q;
	logic                        rvalid_q;
	logic [15:0]                 mem [VRAM_WORDS];

	// Quotient estimate by reciprocal; it is low by at most one
	assign prod = PW'(addr_s1) * PW'(RECIP);

	// Remainder with a single correction
	always_comb begin
		rem_raw = 22'(addr_s2) - 22'(q_s2) * DIV;
		rem     = (rem_raw >= DIV) ? rem_raw - DIV : rem_raw;
	end

	// Advance access strobes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1    <= 1'b0;
			rd_s1    <= 1'b0;
			wr_s2    <= 1'b0;
			rd_s2    <= 1'b0;
			wr_s3    <= 1'b0;
			rd_s3    <= 1'b0;
			rvalid_q <= 1'b0;
		end else begin
			wr_s1    <= req.wr;
			rd_s1    <= req.rd;
			wr_s2    <= wr_s1;
			rd_s2    <= rd_s1;
			wr_s3    <= wr_s2;
			rd_s3    <= rd_s2;
			rvalid_q <= rd_s3;
		end
	end

	// Advance address and data
	always_ff @(posedge clk) begin
		addr_s1 <= req.addr;
		data_s1 <= req.data;
		addr_s2 <= addr_s1;
		q_s2    <= prod[SH+5:SH];
		data_s2 <= data_s1;
		idx_s3  <= rem[AW-1:0];
		data_s3 <= data_s2;
	end

	// Memory array: one write and one registered read
	always_ff @(posedge clk) begin
		if (wr_s3) begin
			mem[idx_s3] <= data_s3;
		end
		if (rd_s3) begin
			rdata_q <= mem[idx_s3];
		end
	end

	assign rsp.busy  = rd_s1 | rd_s2 | rd_s3 | rvalid_q;
	assign rsp.valid = rvalid_q;
	assign rsp.data  = rdata_q;

	a_one_read: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({rd_s1, rd_s2, rd_s3, rvalid_q}) <= 1)
		else $error("more than one read in flight");

	a_rd_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_s1 && rd_s1))
		else $error("read and write issued by one transfer");

endmodule

>>> rtl/video_ram_host_port.sv
// Host port of a video display controller: select latch, 32 registers
// written a byte at a time, video memory store and prefetch, status flags
// and interrupt. Depends on vrhp_pkg, vrhp_stream_if and vrhp_vram.
//
// Each command's result goes to an output register, so commands can follow
// one another every cycle while the result side keeps up. A command that
// prefetches into the read buffer (high byte write of register 1, or high
// byte read with register 2 selected) holds off the next command until the
// word is in the read buffer: the read address is folded modulo the memory
// size in two pipeline stages, the memory read is registered and the read
// word is loaded into the read buffer. Stores go down the same pipeline and
// never stall. Video memory is not cleared at reset.
module video_ram_host_port #(
	parameter int unsigned VRAM_WORDS  = 32768,
	parameter int unsigned VBLANK_LINE = 242
) (
	input logic         clk,
	input logic         arst_n,
	vrhp_stream_if.sink   cmd,
	vrhp_stream_if.source res
);

	logic [15:0]                regs_q [vrhp_pkg::NUM_REGS];
	logic [vrhp_pkg::SEL_W-1:0] sel_q;
	logic [15:0]                rbuf_q;
	logic [7:0]                 status_q;
	logic                       irq_q;
	logic                       out_valid_q;
	vrhp_pkg::res_t             out_q;

	vrhp_pkg::cmd_t      c;
	vrhp_pkg::vram_req_t vram_req;
	vrhp_pkg::vram_rsp_t vram_rsp;
	logic                accept, cmd_ready;
	logic [15:0]         sel_val, hi_val;
	logic [1:0]          step_code;
	logic [7:0]          rdata_d, status_d;
	logic                irq_d, vd_hit, rr_hit;

	assign c         = cmd.data;
	assign cmd_ready = (!out_valid_q || res.ready) && !vram_rsp.busy;
	assign cmd.ready = cmd_ready;
	assign accept    = cmd.valid && cmd_ready;

	assign sel_val   = regs_q[sel_q];
	assign hi_val    = {c.wdata, sel_val[7:0]};
	assign step_code = regs_q[vrhp_pkg::REG_CR][vrhp_pkg::CR_INC_LO +: 2];

	// Line event matches
	assign vd_hit = (c.line == VBLANK_LINE[8:0]) && regs_q[vrhp_pkg::REG_CR][vrhp_pkg::CR_VD_EN];
	assign rr_hit = (({7'd0, c.line} + vrhp_pkg::LINE_OFFSET) == regs_q[vrhp_pkg::REG_RCR])
		&& regs_q[vrhp_pkg::REG_CR][vrhp_pkg::CR_RR_EN];

	// Decode the command: read byte, flags and memory request
	always_comb begin
		rdata_d  = 8'd0;
		status_d = status_q;
		irq_d    = irq_q;
		vram_req = '0;
		unique case (c.func)
			vrhp_pkg::FUNC_READ: begin
				unique case (c.port)
					vrhp_pkg::PORT_SEL: begin
						rdata_d  = status_q;
						status_d = 8'd0;
						irq_d    = 1'b0;
					end
					vrhp_pkg::PORT_DLO: rdata_d = rbuf_q[7:0];
					vrhp_pkg::PORT_DHI: begin
						rdata_d = rbuf_q[15:8];
						if (sel_q == vrhp_pkg::REG_VWR) begin
							vram_req.rd   = 1'b1;
							vram_req.addr = regs_q[vrhp_pkg::REG_MARR][vrhp_pkg::ADDR_W-1:0];
						end
					end
					default: ;
				endcase
			end
			vrhp_pkg::FUNC_WRITE: begin
				if (c.port == vrhp_pkg::PORT_DHI) begin
					if (sel_q == vrhp_pkg::REG_VWR) begin
						vram_req.wr   = 1'b1;
						vram_req.addr = regs_q[vrhp_pkg::REG_MAWR][vrhp_pkg::ADDR_W-1:0];
						vram_req.data = hi_val;
					end else if (sel_q == vrhp_pkg::REG_MARR) begin
						vram_req.rd   = 1'b1;
						vram_req.addr = hi_val[vrhp_pkg::ADDR_W-1:0];
					end
				end
			end
			vrhp_pkg::FUNC_LINE: begin
				if (vd_hit) begin
					status_d[vrhp_pkg::FLAG_VD] = 1'b1;
					irq_d                       = 1'b1;
				end
				if (rr_hit) begin
					status_d[vrhp_pkg::FLAG_RR] = 1'b1;
					irq_d                       = 1'b1;
				end
			end
			default: ;
		endcase
		if (!accept) begin
			vram_req.wr = 1'b0;
			vram_req.rd = 1'b0;
		end
	end

	// Update registers, flags, read buffer and the result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < vrhp_pkg::NUM_REGS; i++) begin
				regs_q[i] <= 16'd0;
			end
			sel_q       <= '0;
			rbuf_q      <= 16'd0;
			status_q    <= 8'd0;
			irq_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (vram_rsp.valid) begin
				rbuf_q <= vram_rsp.data;
			end
			if (accept) begin
				status_q    <= status_d;
				irq_q       <= irq_d;
				out_valid_q <= 1'b1;
				if (c.func == vrhp_pkg::FUNC_WRITE) begin
					unique case (c.port)
						vrhp_pkg::PORT_SEL: sel_q <= c.wdata[vrhp_pkg::SEL_W-1:0];
						vrhp_pkg::PORT_DLO: regs_q[sel_q][7:0] <= c.wdata;
						vrhp_pkg::PORT_DHI: begin
							// The read address takes the stepped prefetch address whole
							if (sel_q == vrhp_pkg::REG_MARR) begin
								regs_q[vrhp_pkg::REG_MARR] <= {1'b0,
									vrhp_pkg::addr_step(hi_val, step_code)};
							end else begin
								regs_q[sel_q][15:8] <= c.wdata;
								if (sel_q == vrhp_pkg::REG_VWR) begin
									regs_q[vrhp_pkg::REG_MAWR] <= {1'b0, vrhp_pkg::addr_step(
										regs_q[vrhp_pkg::REG_MAWR], step_code)};
								end
							end
						end
						default: ;
					endcase
				end else if (c.func == vrhp_pkg::FUNC_READ && c.port == vrhp_pkg::PORT_DHI
						&& sel_q == vrhp_pkg::REG_VWR) begin
					regs_q[vrhp_pkg::REG_MARR] <= {1'b0, vrhp_pkg::addr_step(
						regs_q[vrhp_pkg::REG_MARR], step_code)};
				end
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.rdata <= rdata_d;
			out_q.irq   <= irq_d;
		end
	end

	assign res.valid = out_valid_q;
	assign res.data  = out_q;

	vrhp_vram #(
		.VRAM_WORDS(VRAM_WORDS)
	) u_vram (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (vram_req),
		.rsp   (vram_rsp)
	);

	a_irq_flags: assert property (@(posedge clk) disable iff (!arst_n)
		irq_q == (status_q != 8'd0))
		else $error("interrupt and status flags disagree");

	a_status_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && c.func == vrhp_pkg::FUNC_READ && c.port == vrhp_pkg::PORT_SEL)
		|=> (status_q == 8'd0 && !irq_q))
		else $error("status read did not clear flags");

	a_buf_load: assert property (@(posedge clk) disable iff (!arst_n)
		vram_rsp.valid |-> !accept)
		else $error("read buffer load raced a transfer");

	a_wr_addr_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && c.func == vrhp_pkg::FUNC_WRITE && c.port == vrhp_pkg::PORT_DHI
		&& sel_q == vrhp_pkg::REG_VWR) |=> !regs_q[vrhp_pkg::REG_MAWR][15])
		else $error("write address left 15-bit range");

endmodule

>>> verif/tb.sv
// Testbench for video_ram_host_port: directed and random host accesses checked
// against a cycle-free model of the register file, read buffer and flags.
// Depends on vrhp_pkg, vrhp_stream_if and the video_ram_host_port RTL.
module tb;

	localparam int unsigned VRAM_WORDS  = 32768;
	localparam int unsigned VBLANK_LINE = 242;
	localparam logic [1:0]  FUNC_NONE   = 2'd3;
	localparam int unsigned IDLE_PCT    = 29;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;

	vrhp_stream_if #(.T(vrhp_pkg::cmd_t)) cmd_if ();
	vrhp_stream_if #(.T(vrhp_pkg::res_t)) res_if ();

	video_ram_host_port #(
		.VRAM_WORDS(VRAM_WORDS),
		.VBLANK_LINE(VBLANK_LINE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_if),
		.res(res_if)
	);

	// Shadow copy of the block state
	logic [15:0] shadow_regs [vrhp_pkg::NUM_REGS];
	logic [4:0]  shadow_sel;
	logic [15:0] shadow_rbuf;
	logic [15:0] shadow_vram [VRAM_WORDS];
	bit          vram_written [VRAM_WORDS];
	logic [7:0]  shadow_flags;
	logic        shadow_irq;

	vrhp_pkg::res_t resp_due [$];
	vrhp_pkg::res_t resp_want;
	logic [15:0]    burst_starts [$];
	int unsigned    items_sent;
	int unsigned    mismatches;
	int unsigned    cycle_count;
	bit             steady;
	bit             stall_req;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int unsigned vram_index(input logic [15:0] addr);
		return (int'(addr) & 'h7fff) % VRAM_WORDS;
	endfunction

	// Advance an address by the increment that the control register selects
	function automatic logic [15:0] step_addr(input logic [15:0] addr);
		int unsigned step_words [4];
		step_words = '{1, 32, 64, 128};
		return 16'(((int'(addr) & 'h7fff)
			+ step_words[shadow_regs[vrhp_pkg::REG_CR][vrhp_pkg::CR_INC_LO +: 2]])
			& 'h7fff);
	endfunction

	function automatic void refill_rbuf();
		shadow_rbuf = shadow_vram[vram_index(shadow_regs[vrhp_pkg::REG_MARR])];
		shadow_regs[vrhp_pkg::REG_MARR] = step_addr(shadow_regs[vrhp_pkg::REG_MARR]);
	endfunction

	// True when this access would prefetch a word that was never stored
	function automatic bit reads_unwritten(input vrhp_pkg::cmd_t c);
		if (c.func == vrhp_pkg::FUNC_READ && c.port == vrhp_pkg::PORT_DHI
				&& shadow_sel == vrhp_pkg::REG_VWR)
			return !vram_written[vram_index(shadow_regs[vrhp_pkg::REG_MARR])];
		if (c.func == vrhp_pkg::FUNC_WRITE && c.port == vrhp_pkg::PORT_DHI
				&& shadow_sel == vrhp_pkg::REG_MARR)
			return !vram_written[vram_index({c.wdata,
				shadow_regs[vrhp_pkg::REG_MARR][7:0]})];
		return 1'b0;
	endfunction

	// Apply one access to the shadow state and return the byte and irq it yields
	function automatic vrhp_pkg::res_t host_access(input vrhp_pkg::cmd_t c);
		vrhp_pkg::res_t r;
		logic [4:0]     s;
		r = '0;
		s = shadow_sel;
		case (c.func)
			vrhp_pkg::FUNC_READ: begin
				case (c.port)
					vrhp_pkg::PORT_SEL: begin
						r.rdata = shadow_flags;
						shadow_flags = '0;
						shadow_irq = 1'b0;
					end
					vrhp_pkg::PORT_DLO: r.rdata = shadow_rbuf[7:0];
					vrhp_pkg::PORT_DHI: begin
						r.rdata = shadow_rbuf[15:8];
						if (s == vrhp_pkg::REG_VWR)
							refill_rbuf();
					end
					default: ;
				endcase
			end
			vrhp_pkg::FUNC_WRITE: begin
				case (c.port)
					vrhp_pkg::PORT_SEL: shadow_sel = c.wdata[4:0];
					vrhp_pkg::PORT_DLO: shadow_regs[s][7:0] = c.wdata;
					vrhp_pkg::PORT_DHI: begin
						shadow_regs[s][15:8] = c.wdata;
						if (s == vrhp_pkg::REG_VWR) begin
							shadow_regs[vrhp_pkg::REG_MAWR] =
								shadow_regs[vrhp_pkg::REG_MAWR] & 16'h7fff;
							shadow_vram[vram_index(shadow_regs[vrhp_pkg::REG_MAWR])] =
								shadow_regs[vrhp_pkg::REG_VWR];
							vram_written[vram_index(shadow_regs[vrhp_pkg::REG_MAWR])] = 1'b1;
							shadow_regs[vrhp_pkg::REG_MAWR] =
								step_addr(shadow_regs[vrhp_pkg::REG_MAWR]);
						end else if (s == vrhp_pkg::REG_MARR) begin
							refill_rbuf();
						end
					end
					default: ;
				endcase
			end
			vrhp_pkg::FUNC_LINE: begin
				if (int'(c.line) == VBLANK_LINE
						&& shadow_regs[vrhp_pkg::REG_CR][vrhp_pkg::CR_VD_EN]) begin
					shadow_flags[vrhp_pkg::FLAG_VD] = 1'b1;
					shadow_irq = 1'b1;
				end
				if (int'(c.line) + int'(vrhp_pkg::LINE_OFFSET)
						== int'(shadow_regs[vrhp_pkg::REG_RCR]) &&
						shadow_regs[vrhp_pkg::REG_CR][vrhp_pkg::CR_RR_EN]) begin
					shadow_flags[vrhp_pkg::FLAG_RR] = 1'b1;
					shadow_irq = 1'b1;
				end
			end
			default: ;
		endcase
		r.irq = shadow_irq;
		return r;
	endfunction

	// Offer one access, wait for its transfer and queue the expected result
	task automatic issue_access(input vrhp_pkg::cmd_t c);
		if (reads_unwritten(c))
			c.port = vrhp_pkg::PORT_DLO;
		if (!steady)
			while ($urandom_range(99) < IDLE_PCT) begin
				cmd_if.valid <= 1'b0;
				@(negedge clk);
			end
		cmd_if.valid <= 1'b1;
		cmd_if.data  <= c;
		@(posedge clk);
		while (!cmd_if.ready)
			@(posedge clk);
		resp_due.push_back(host_access(c));
		if (c.func != FUNC_NONE
				&& !(c.func != vrhp_pkg::FUNC_LINE && c.port == vrhp_pkg::PORT_UNUSED))
			items_sent++;
		@(negedge clk);
	endtask

	task automatic host_write(input logic [1:0] port, input logic [7:0] b);
		vrhp_pkg::cmd_t c;
		c.func  = vrhp_pkg::FUNC_WRITE;
		c.port  = port;
		c.wdata = b;
		c.line  = 9'($urandom_range(511));
		issue_access(c);
	endtask

	task automatic host_read(input logic [1:0] port);
		vrhp_pkg::cmd_t c;
		c.func  = vrhp_pkg::FUNC_READ;
		c.port  = port;
		c.wdata = 8'($urandom_range(255));
		c.line  = 9'($urandom_range(511));
		issue_access(c);
	endtask

	task automatic line_event(input logic [8:0] line);
		vrhp_pkg::cmd_t c;
		c.func  = vrhp_pkg::FUNC_LINE;
		c.port  = 2'($urandom_range(3));
		c.wdata = 8'($urandom_range(255));
		c.line  = line;
		issue_access(c);
	endtask

	// Select a register and write both bytes, low first
	task automatic write_reg(input logic [4:0] sel, input logic [15:0] value);
		host_write(vrhp_pkg::PORT_SEL, {3'($urandom_range(7)), sel});
		host_write(vrhp_pkg::PORT_DLO, value[7:0]);
		host_write(vrhp_pkg::PORT_DHI, value[15:8]);
	endtask

	task automatic test_directed();
		vrhp_pkg::cmd_t c;
		host_read(vrhp_pkg::PORT_SEL);
		host_write(vrhp_pkg::PORT_UNUSED, 8'hff);
		host_read(vrhp_pkg::PORT_UNUSED);
		// unused func value with every field at its maximum
		c.func  = FUNC_NONE;
		c.port  = vrhp_pkg::PORT_DHI;
		c.wdata = 8'hff;
		c.line  = 9'h1ff;
		issue_access(c);
		// both flag enables on, largest address step
		host_write(vrhp_pkg::PORT_SEL, 8'he0 | 8'(vrhp_pkg::REG_CR));
		host_write(vrhp_pkg::PORT_DLO, 8'h0c);
		host_write(vrhp_pkg::PORT_DHI, 8'h18);
		// store at the top of memory from an address with bit 15 set, then wrap
		write_reg(vrhp_pkg::REG_MAWR, 16'hffff);
		write_reg(vrhp_pkg::REG_VWR, 16'h1234);
		host_write(vrhp_pkg::PORT_DLO, 8'h78);
		host_write(vrhp_pkg::PORT_DHI, 8'h56);
		// prefetch both words back
		write_reg(vrhp_pkg::REG_MARR, 16'hffff);
		host_write(vrhp_pkg::PORT_SEL, 8'h40 | 8'(vrhp_pkg::REG_VWR));
		host_read(vrhp_pkg::PORT_DLO);
		host_read(vrhp_pkg::PORT_DHI);
		// vertical blank and raster match on the same line
		write_reg(vrhp_pkg::REG_RCR, 16'(VBLANK_LINE) + vrhp_pkg::LINE_OFFSET);
		line_event(9'(VBLANK_LINE));
		host_read(vrhp_pkg::PORT_SEL);
		line_event(9'h1ff);
	endtask

	// Mostly well-formed register sequences, with some raw noise mixed in
	task automatic run_traffic(input int unsigned count);
		int unsigned    goal;
		int unsigned    k;
		int unsigned    n;
		logic [15:0]    a;
		logic [8:0]     l;
		vrhp_pkg::cmd_t c;
		goal = items_sent + count;
		while (items_sent < goal) begin
			case ($urandom_range(9))
				0, 1: begin
					// store burst
					a = 16'($urandom_range(65535));
					write_reg(vrhp_pkg::REG_MAWR, a);
					if (burst_starts.size() > 32)
						void'(burst_starts.pop_front());
					burst_starts.push_back(a & 16'h7fff);
					host_write(vrhp_pkg::PORT_SEL, 8'(vrhp_pkg::REG_VWR));
					k = $urandom_range(2, 12);
					for (n = 0; n < k; n++) begin
						host_write(vrhp_pkg::PORT_DLO, 8'($urandom_range(255)));
						host_write(vrhp_pkg::PORT_DHI, 8'($urandom_range(255)));
					end
				end
				2, 3: begin
					// read back a stored burst through the read buffer
					if (burst_starts.size() == 0) begin
						host_read(vrhp_pkg::PORT_SEL);
					end else begin
						a = burst_starts[$urandom_range(burst_starts.size() - 1)];
						a[15] = 1'($urandom_range(1));
						write_reg(vrhp_pkg::REG_MARR, a);
						host_write(vrhp_pkg::PORT_SEL, 8'(vrhp_pkg::REG_VWR));
						k = $urandom_range(2, 12);
						for (n = 0; n < k; n++) begin
							host_read(vrhp_pkg::PORT_DLO);
							host_read(vrhp_pkg::PORT_DHI);
						end
					end
				end
				4: begin
					// control: enables mostly on, random step
					a = 16'($urandom_range(65535));
					a[vrhp_pkg::CR_VD_EN] = ($urandom_range(3) != 0);
					a[vrhp_pkg::CR_RR_EN] = ($urandom_range(3) != 0);
					write_reg(vrhp_pkg::REG_CR, a);
				end
				5: begin
					// raster compare around a chosen line
					l = 9'($urandom_range(511));
					if ($urandom_range(3) == 0)
						write_reg(vrhp_pkg::REG_RCR, 16'($urandom_range(65535)));
					else
						write_reg(vrhp_pkg::REG_RCR, 16'(l) + vrhp_pkg::LINE_OFFSET);
					line_event(l);
					line_event(9'(VBLANK_LINE));
					line_event(9'($urandom_range(511)));
					host_read(vrhp_pkg::PORT_SEL);
				end
				6, 7: begin
					k = $urandom_range(1, 4);
					for (n = 0; n < k; n++) begin
						c.func  = 2'($urandom_range(3));
						c.port  = 2'($urandom_range(3));
						c.wdata = 8'($urandom_range(255));
						c.line  = 9'($urandom_range(511));
						issue_access(c);
					end
				end
				8: host_read(vrhp_pkg::PORT_SEL);
				default: line_event(9'($urandom_range(511)));
			endcase
		end
	endtask

	task automatic test_random();
		run_traffic(200);
	endtask

	task automatic test_steady();
		steady = 1'b1;
		run_traffic(100);
		steady = 1'b0;
	endtask

	// Hold the result side while stores keep coming, so the input stalls
	task automatic test_backpressure();
		int unsigned n;
		stall_req = 1'b1;
		host_write(vrhp_pkg::PORT_SEL, 8'(vrhp_pkg::REG_VWR));
		for (n = 0; n < 40; n++) begin
			host_write(vrhp_pkg::PORT_DLO, 8'($urandom_range(255)));
			host_write(vrhp_pkg::PORT_DHI, 8'($urandom_range(255)));
		end
		while (stall_req)
			@(negedge clk);
	endtask

	// Result side: random ready, with a long hold when asked
	initial begin
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_req) begin
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				stall_req = 1'b0;
			end else begin
				res_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (res_if.valid && res_if.ready) begin
			if (resp_due.size() == 0) begin
				$display("%0t: unexpected result rdata %02h irq %0b", $time,
					res_if.data.rdata, res_if.data.irq);
				mismatches++;
			end else begin
				resp_want = resp_due.pop_front();
				if (res_if.data.rdata !== resp_want.rdata) begin
					$display("%0t: rdata expected %02h actual %02h", $time,
						resp_want.rdata, res_if.data.rdata);
					mismatches++;
				end
				if (res_if.data.irq !== resp_want.irq) begin
					$display("%0t: irq expected %0b actual %0b", $time,
						resp_want.irq, res_if.data.irq);
					mismatches++;
				end
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_if.valid = 1'b0;
		cmd_if.data = '0;
		steady = 1'b0;
		stall_req = 1'b0;
		items_sent = 0;
		mismatches = 0;
		cycle_count = 0;
		for (int i = 0; i < vrhp_pkg::NUM_REGS; i++)
			shadow_regs[i] = '0;
		shadow_sel = '0;
		shadow_rbuf = '0;
		shadow_flags = '0;
		shadow_irq = 1'b0;
		for (int i = 0; i < VRAM_WORDS; i++)
			vram_written[i] = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random();
		test_backpressure();
		test_steady();
		test_random();

		// drain outstanding results
		cmd_if.valid <= 1'b0;
		while (resp_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
